@@ rtl/rmt_pkg.sv @@
// ----------------------------------------------------------------------------
// rmt_pkg
// Shared types for the running median tracker: the per-cell operation code.
// ----------------------------------------------------------------------------
package rmt_pkg;

   // Operation that all cells of a chain apply together
   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_PUSH   = 2'd2,
      OP_POP    = 2'd3
   } cell_op_type;

endpackage

@@ rtl/rmt_cell.sv @@
// ----------------------------------------------------------------------------
// rmt_cell
// One slot of a sorted chain. Holds one value and trades it with its
// neighbors on insert, push-to-head and pop-from-head.
// ----------------------------------------------------------------------------
module rmt_cell #(
   parameter int W      = 16,
   parameter bit ASCEND = 1'b0
) (
   input  logic                 clock,
   input  rmt_pkg::cell_op_type op,
   input  logic                 occ,
   input  logic [W-1:0]         v,
   input  logic [W-1:0]         left_val,
   input  logic                 left_keep,
   input  logic [W-1:0]         right_val,
   output logic [W-1:0]         val,
   output logic                 keep
);
   import rmt_pkg::*;

   logic [W-1:0] val_ff;
   logic [W-1:0] val_in;

   // keep: this occupied slot stays ahead of the new value in chain order
   always_comb begin
      if (ASCEND) begin
         keep = occ && (val_ff <= v);
      end else begin
         keep = occ && (val_ff >= v);
      end
   end

   always_comb begin
      case (op)
         OP_INSERT: begin
            if (keep) begin
               val_in = val_ff;
            end else if (left_keep) begin
               val_in = v;
            end else begin
               val_in = left_val;
            end
         end
         OP_PUSH: val_in = left_val;
         OP_POP:  val_in = right_val;
         default: val_in = val_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign val = val_ff;

endmodule

@@ rtl/rmt_chain.sv @@
// ----------------------------------------------------------------------------
// rmt_chain
// Row of cells kept sorted from the head: descending for the lower half,
// ascending for the upper half, so the head always holds the half's top.
// ----------------------------------------------------------------------------
module rmt_chain #(
   parameter int W      = 16,
   parameter int DEPTH  = 513,
   parameter bit ASCEND = 1'b0,
   parameter int CW     = 10
) (
   input  logic                 clock,
   input  rmt_pkg::cell_op_type op,
   input  logic [CW-1:0]        cnt,
   input  logic [W-1:0]         v,
   input  logic [W-1:0]         head_in,
   output logic [W-1:0]         head
);
   import rmt_pkg::*;

   logic [W-1:0]     val  [DEPTH];
   logic [DEPTH-1:0] keep;
   logic [DEPTH-1:0] occ;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [W-1:0] left_val;
      logic         left_keep;
      logic [W-1:0] right_val;

      assign occ[i] = CW'(i) < cnt;

      if (i == 0) begin : g_head
         assign left_val  = head_in;
         assign left_keep = 1'b0;
      end else begin : g_body
         assign left_val  = val[i-1];
         assign left_keep = keep[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_val = val[i];
      end else begin : g_mid
         assign right_val = val[i+1];
      end

      rmt_cell #(
         .W      (W),
         .ASCEND (ASCEND)
      ) u_cell (
         .clock     (clock),
         .op        (op),
         .occ       (occ[i]),
         .v         (v),
         .left_val  (left_val),
         .left_keep (left_keep),
         .right_val (right_val),
         .val       (val[i]),
         .keep      (keep[i])
      );
   end

   assign head = val[0];

endmodule

@@ rtl/running_median_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// running_median_tracker_unit
// Running median over a stream of samples, kept in two sorted cell chains.
// ----------------------------------------------------------------------------
// Each accepted item inserts its sample (or restarts the set with it) and
// produces one result item: the lower median, the stored count and a flag set
// when the sample was dropped because CAPACITY values are already held. An
// item goes through the accept step, which shifts the sample into the lower
// or upper chain, the balance step, which moves one head across to rebalance
// the two chains, and the report step, which loads the result register. The
// result register lets the next item be accepted while a result waits; a new
// result waits in the report step until the previous one is taken. Only the
// low VALUE_BITS bits of a sample (16 at most) are stored.
// ----------------------------------------------------------------------------
module running_median_tracker_unit #(
   parameter int CAPACITY   = 1024,
   parameter int VALUE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample
   input  logic        req_tuser,   // [0] restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] median, [26:16] count, [31:27] zero
   output logic        rsp_tuser    // [0] full_res
);
   import rmt_pkg::*;

   localparam int VW   = (VALUE_BITS < 16) ? VALUE_BITS : 16;
   localparam int HALF = CAPACITY / 2 + 1;
   localparam int CW   = $clog2(HALF + 1);
   localparam int TW   = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_BAL  = 3'b010,
      ST_RPT  = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   logic [CW-1:0] nl_ff, nl_in;
   logic [CW-1:0] nu_ff, nu_in;
   logic          full_ff, full_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_median_ff, rsp_median_in;
   logic [10:0]   rsp_count_ff, rsp_count_in;
   logic          rsp_full_ff, rsp_full_in;

   cell_op_type   lo_op, up_op;
   logic [VW-1:0] lo_head_in, up_head_in;
   logic [VW-1:0] lo_head, up_head;
   logic [VW-1:0] v;
   logic [CW-1:0] eff_nl, eff_nu;
   logic [TW-1:0] eff_total, total;
   logic          accept, is_full, to_lower, rsp_free;

   assign v          = VW'(req_tdata);
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      eff_nl    = req_tuser ? '0 : nl_ff;
      eff_nu    = req_tuser ? '0 : nu_ff;
      eff_total = TW'(eff_nl) + TW'(eff_nu);
      total     = TW'(nl_ff) + TW'(nu_ff);
      is_full   = eff_total >= TW'(CAPACITY);
      to_lower  = (eff_nl == '0) || (v <= lo_head);
   end

   always_comb begin
      state_in      = state_ff;
      nl_in         = nl_ff;
      nu_in         = nu_ff;
      full_in       = full_ff;
      lo_op         = OP_HOLD;
      up_op         = OP_HOLD;
      lo_head_in    = v;
      up_head_in    = v;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_median_in = rsp_median_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_full_in   = rsp_full_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               full_in  = is_full;
               nl_in    = eff_nl;
               nu_in    = eff_nu;
               state_in = ST_BAL;
               if (!is_full) begin
                  if (to_lower) begin
                     lo_op = OP_INSERT;
                     nl_in = eff_nl + 1'b1;
                  end else begin
                     up_op = OP_INSERT;
                     nu_in = eff_nu + 1'b1;
                  end
               end
            end
         end
         ST_BAL: begin
            state_in = ST_RPT;
            if ((CW+1)'(nl_ff) > (CW+1)'(nu_ff) + 1'b1) begin
               // lower half too big: its top moves to the upper head
               lo_op      = OP_POP;
               up_op      = OP_PUSH;
               up_head_in = lo_head;
               nl_in      = nl_ff - 1'b1;
               nu_in      = nu_ff + 1'b1;
            end else if (nu_ff > nl_ff) begin
               up_op      = OP_POP;
               lo_op      = OP_PUSH;
               lo_head_in = up_head;
               nu_in      = nu_ff - 1'b1;
               nl_in      = nl_ff + 1'b1;
            end
         end
         ST_RPT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_median_in = 16'(lo_head);
               rsp_count_in  = 11'(total);
               rsp_full_in   = full_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         nl_ff        <= '0;
         nu_ff        <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nl_ff        <= nl_in;
         nu_ff        <= nu_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_median_ff <= rsp_median_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_full_ff   <= rsp_full_in;
   end

   // lower half: descending, head is the median
   rmt_chain #(
      .W      (VW),
      .DEPTH  (HALF),
      .ASCEND (1'b0),
      .CW     (CW)
   ) u_lower (
      .clock   (clock),
      .op      (lo_op),
      .cnt     (eff_nl),
      .v       (v),
      .head_in (lo_head_in),
      .head    (lo_head)
   );

   rmt_chain #(
      .W      (VW),
      .DEPTH  (HALF),
      .ASCEND (1'b1),
      .CW     (CW)
   ) u_upper (
      .clock   (clock),
      .op      (up_op),
      .cnt     (eff_nu),
      .v       (v),
      .head_in (up_head_in),
      .head    (up_head)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_count_ff, rsp_median_ff};
   assign rsp_tuser  = rsp_full_ff;

endmodule

@@ rtl/rmt_checker.sv @@
// ----------------------------------------------------------------------------
// rmt_checker
// Port-level checks for the running median tracker, bound to the top level.
// ----------------------------------------------------------------------------
module rmt_checker #(
   parameter int CAPACITY = 1024
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // one item in flight: no accept right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while previous item in flight");

   // a dropped sample is only reported with a full store
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[26:16] == 11'(CAPACITY))
      else $error("full flag with store not full");

   // every result follows an insertion or a full store
   a_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[26:16] != 11'd0)
      else $error("result reports an empty store");

endmodule

bind running_median_tracker_unit rmt_checker #(
   .CAPACITY (CAPACITY)
) u_rmt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stream-level test of running_median_tracker_unit.
// ----------------------------------------------------------------------------
// A directed opener covers extreme and tied samples, restarts and insertion
// into an empty store. The random part is mostly restart-led runs of random
// samples, plus one run long enough to fill the store, drop samples and
// restart while full. Each accepted item updates a sorted copy of the stored
// set, and each result is checked against the oldest prediction. Both sides
// idle at random. The receiver also holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;

   localparam int CAPACITY    = 1024;
   localparam int VALUE_BITS  = 16;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_START  = 300;
   localparam int HOLD_CYCLES = 400;
   localparam int RUN_ITEMS   = 1320;

   typedef struct {
      logic [15:0] value;
      logic        restart;
      logic        drain;      // wait for every result before offering this item
   } sample_item_type;

   typedef struct {
      logic [15:0] median;
      logic [10:0] count;
      logic        full;
   } median_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;    // [15:0] sample
   logic        req_tuser  = 1'b0;  // [0] restart
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // [15:0] median, [26:16] count, [31:27] zero
   logic        rsp_tuser;          // [0] full_res

   sample_item_type   sample_queue[$];
   median_result_type pending_results[$];
   logic [15:0]       held_values[$];   // stored multiset, ascending
   sample_item_type   offered_item;
   median_result_type expected_result;

   int   error_count    = 0;
   int   accepted_count = 0;
   int   checked_count  = 0;
   int   cycle_count    = 0;
   int   send_gap       = 0;
   int   send_free      = 0;
   int   recv_stall     = 0;
   int   recv_free      = 0;
   logic recv_hold      = 1'b0;

   always #1 clock = ~clock;

   running_median_tracker_unit #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [15:0] random_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 20) return 16'($urandom_range(0, 15));        // many ties
      if (r < 28) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      if (r < 34) return 16'hFFFF - 16'($urandom_range(0, 7));
      return 16'($urandom());
   endfunction

   // lower median = entry (n-1)/2 of the sorted set
   function automatic median_result_type predict_median(sample_item_type it);
      median_result_type r;
      int pos;
      r.full = 1'b0;
      if (it.restart) held_values.delete();
      if (held_values.size() >= CAPACITY) begin
         r.full = 1'b1;
      end else begin
         pos = 0;
         while (pos < held_values.size() && held_values[pos] <= it.value) pos++;
         held_values.insert(pos, it.value);
      end
      r.count  = 11'(held_values.size());
      r.median = (held_values.size() > 0) ? held_values[(held_values.size() - 1) / 2]
                                          : 16'h0000;
      return r;
   endfunction

   task automatic add_item(input logic [15:0] v, input logic rs, input logic dr);
      sample_item_type it;
      it.value   = v;
      it.restart = rs;
      it.drain   = dr;
      sample_queue.push_back(it);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
               checked_count, what, got, want);
      error_count++;
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            pending_results.push_back(predict_median(offered_item));
            accepted_count++;
            if (send_free > 0) begin
               send_free--;
               send_gap = 0;
            end else if ($urandom_range(0, 99) < 2) begin
               send_free = $urandom_range(30, 80);
               send_gap  = 0;
            end else begin
               send_gap = pick_gap();
            end
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (sample_queue.size() > 0 &&
                         !(sample_queue[0].drain && pending_results.size() > 0)) begin
               offered_item = sample_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= offered_item.value;
               req_tuser  <= offered_item.restart;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (recv_hold) begin
         rsp_tready <= 1'b0;
      end else if (recv_stall > 0) begin
         recv_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (recv_free > 0) begin
            recv_free--;
         end else if ($urandom_range(0, 99) < 2) begin
            recv_free = $urandom_range(30, 80);
         end else if ($urandom_range(0, 99) < 30) begin
            recv_stall = pick_gap();
         end
      end
   end

   // long hold-off so the block fills and stalls its input
   initial begin
      while (accepted_count < HOLD_START) @(negedge clock);
      recv_hold = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      recv_hold = 1'b0;
   end

   // checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with none pending, tdata", int'(rsp_tdata), 0);
         end else begin
            expected_result = pending_results.pop_front();
            if (rsp_tdata[15:0] !== expected_result.median)
               report_mismatch("median", int'(rsp_tdata[15:0]),
                               int'(expected_result.median));
            if (rsp_tdata[26:16] !== expected_result.count)
               report_mismatch("count", int'(rsp_tdata[26:16]),
                               int'(expected_result.count));
            if (rsp_tuser !== expected_result.full)
               report_mismatch("full_res", int'(rsp_tuser), int'(expected_result.full));
         end
         checked_count++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** running_median_tracker_unit: FAILED **");
         $finish;
      end
   end

   initial begin
      int seg_len;

      // directed: empty store without restart, extremes, ties, restarts
      add_item(16'h1234, 1'b0, 1'b0);
      add_item(16'h0000, 1'b0, 1'b0);
      add_item(16'hFFFF, 1'b0, 1'b0);
      add_item(16'hFFFF, 1'b0, 1'b0);
      add_item(16'h0000, 1'b0, 1'b0);
      add_item(16'hAAAA, 1'b0, 1'b0);
      add_item(16'h5555, 1'b0, 1'b0);
      add_item(16'h8000, 1'b0, 1'b0);
      add_item(16'h7FFF, 1'b0, 1'b0);
      add_item(16'h0001, 1'b0, 1'b0);
      add_item(16'hFFFF, 1'b1, 1'b0);
      add_item(16'h0000, 1'b0, 1'b0);
      add_item(16'h0000, 1'b1, 1'b0);
      add_item(16'h4321, 1'b1, 1'b0);
      add_item(16'h4321, 1'b0, 1'b0);
      add_item(16'h4321, 1'b0, 1'b0);
      add_item(16'h4320, 1'b0, 1'b0);
      add_item(16'h4322, 1'b0, 1'b0);

      // fill the store, drop a few samples, then restart while full
      add_item(random_value(), 1'b1, 1'b1);
      repeat (CAPACITY - 1) add_item(random_value(), 1'b0, 1'b0);
      repeat (6) add_item(random_value(), 1'b0, 1'b0);
      add_item(random_value(), 1'b1, 1'b0);

      // short runs, mostly opened by a restart
      while (sample_queue.size() < RUN_ITEMS) begin
         seg_len = $urandom_range(1, 40);
         add_item(random_value(), ($urandom_range(0, 7) != 0), ($urandom_range(0, 9) == 0));
         repeat (seg_len - 1) add_item(random_value(), 1'b0, 1'b0);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (sample_queue.size() > 0 || req_tvalid) @(posedge clock);
      while (pending_results.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (error_count == 0 && pending_results.size() == 0) begin
         $display("** running_median_tracker_unit: PASSED **");
      end else begin
         $display("** running_median_tracker_unit: FAILED **");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/rmt_pkg.sv
rtl/rmt_cell.sv
rtl/rmt_chain.sv
rtl/running_median_tracker_unit.sv
rtl/rmt_checker.sv
bench/tb.sv
